@@ rtl/core/cmc_pkg.sv @@
package cmc_pkg;

    localparam int unsigned DefBuckets = 1024;
    localparam int unsigned DefWays = 2;
    localparam int unsigned MetricCount = 5;
    localparam logic [31:0] DefTimeout = 32'(60 * 60);

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_LOCK   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_LOCKED    = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        address_is_ipv6;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [2:0]  metric_index;
        logic [31:0] metric_value_in;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] metric_value_out;
        logic [4:0]  lock_mask;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start hash
        logic hash_step; // one ipv6 hash word
        logic rd_way;    // issue read of current way
        logic cmp_way;   // compare returned way
        logic next_way;
        logic execute;   // decide and write back
        logic clr_step;  // clear one valid row
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic last_way;
        logic found;
        logic clr_done;
    } sts_t;

endpackage

@@ rtl/core/cmc_if.sv @@
interface cmc_req_if;
    logic              valid;
    logic              ready;
    cmc_pkg::req_t     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cmc_rsp_if;
    logic              valid;
    logic              ready;
    cmc_pkg::rsp_t     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cmc_cfg_if;
    logic              valid;
    logic              ready;
    logic [31:0]       payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/connection_metrics_cache_core.sv @@
// connection metrics cache: per-connection tcp metrics keyed by address pair
// channels: req (request beat in), rsp (one result beat per request),
// cfg (write of the aging timeout in seconds, reset value 3600)
// a request beat is taken only while the block is idle; one request at a time
// a request is accepted, hashed (ipv4 directly, ipv6 over its address words in
// hash steps), then each way is walked with a read and a compare until a hit or
// the last way, then executed; the result then sits in the output register
// the entry memory is walked way by way, and a new request is taken only once
// the result of the last one has been taken by the receiver
// the rsp beat holds until taken; a stalled receiver keeps req ready low
// after reset a clearing pass zeroes the valid rows; req ready stays low
// meanwhile, cfg writes are taken at all times
// entry keys, lock bits, timestamps and metric values live in memories with
// no reset; only valid rows are ever trusted
module connection_metrics_cache_core #(
    parameter int unsigned BUCKETS = cmc_pkg::DefBuckets,
    parameter int unsigned WAYS = cmc_pkg::DefWays
) (
    input logic        clk,
    input logic        rst_n,
    cmc_req_if.sink    req,
    cmc_rsp_if.source  rsp,
    cmc_cfg_if.sink    cfg
);

    cmc_pkg::cmd_t cmd;
    cmc_pkg::sts_t sts;

    // config always accepted
    assign cfg.ready = 1'b1;

    cmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cmc_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.payload),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.payload),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp.payload)
    );

endmodule

@@ rtl/core/cmc_ctrl.sv @@
module cmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  cmc_pkg::sts_t  sts,
    output cmc_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_EXEC  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_way = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_way = 1'b1;
                if (sts.found || sts.last_way)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.next_way = 1'b1;
                    state_next = S_RD;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next_way rides along with cmp_way
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.hash_step, cmd.rd_way, cmd.cmp_way, cmd.execute,
                  cmd.clr_step}))
        else $error("more than one command");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_HASH)
        else $error("load did not start hash");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid)
        else $error("execute without result");

endmodule

@@ rtl/core/cmc_dp.sv @@
module cmc_dp #(
    parameter int unsigned BUCKETS = cmc_pkg::DefBuckets,
    parameter int unsigned WAYS = cmc_pkg::DefWays
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cmc_pkg::req_t  req,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_data,
    input  cmc_pkg::cmd_t  cmd,
    output cmc_pkg::sts_t  sts,
    output cmc_pkg::rsp_t  rsp
);

    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned SLOTS = BUCKETS * WAYS;
    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned MC = cmc_pkg::MetricCount;

    // entry record in one memory row (metric values separate)
    typedef struct packed {
        logic        v6;
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] dh;
        logic [63:0] dl;
        logic [31:0] touch;
        logic [4:0]  locks;
    } ent_t;

    ent_t        ent_mem [SLOTS];
    logic [31:0] val_mem [SLOTS][MC];
    logic [WAYS-1:0] vld_mem [BUCKETS];

    logic [31:0] timeout_reg;
    cmc_pkg::req_t r_reg;
    logic [31:0] hs_reg, hd_reg;
    logic [1:0]  hcnt_reg;
    logic [WW-1:0] way_reg;
    logic [WAYS-1:0] vrow_reg;
    ent_t        ent_rd;
    logic [31:0] vals_rd [MC];
    logic        found_reg;
    logic [WW-1:0] fway_reg;
    logic [BW:0] clr_reg;
    cmc_pkg::rsp_t rsp_reg;

    logic [63:0] shi, slo, dhi, dlo;
    logic [BW-1:0] bucket;
    logic [SW-1:0] slot_rd, slot_hit;
    logic        match;
    logic [31:0] hs_word, hd_word;

    assign shi = r_reg.address_is_ipv6 ? r_reg.source_addr_high : 64'd0;
    assign slo = r_reg.address_is_ipv6 ? r_reg.source_addr_low
                                       : {32'd0, r_reg.source_addr_low[31:0]};
    assign dhi = r_reg.address_is_ipv6 ? r_reg.dest_addr_high : 64'd0;
    assign dlo = r_reg.address_is_ipv6 ? r_reg.dest_addr_low
                                       : {32'd0, r_reg.dest_addr_low[31:0]};

    assign bucket  = BW'((hs_reg ^ hd_reg) & 32'(BUCKETS - 1));
    assign slot_rd = SW'(32'(bucket) * 32'(WAYS) + 32'(way_reg));
    assign slot_hit = SW'(32'(bucket) * 32'(WAYS) + 32'(fway_reg));

    always_comb
    begin
        case (hcnt_reg)
            2'd0: hs_word = shi[31:0];
            2'd1: hs_word = slo[63:32];
            default: hs_word = slo[31:0];
        endcase
        case (hcnt_reg)
            2'd0: hd_word = dhi[31:0];
            2'd1: hd_word = dlo[63:32];
            default: hd_word = dlo[31:0];
        endcase
    end

    assign match = vrow_reg[way_reg] && ent_rd.v6 == r_reg.address_is_ipv6 &&
                   ent_rd.sh == shi && ent_rd.sl == slo &&
                   ent_rd.dh == dhi && ent_rd.dl == dlo;

    assign sts.hash_done = !r_reg.address_is_ipv6 || hcnt_reg == 2'd2;
    assign sts.last_way  = (32'(way_reg) == 32'(WAYS - 1));
    assign sts.found     = match;
    assign sts.clr_done  = (32'(clr_reg) == 32'(BUCKETS - 1));
    assign rsp = rsp_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= cmc_pkg::DefTimeout;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + (BW + 1)'(1);
            end
        end
    end

    // hash and way walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg <= req;
            hcnt_reg <= 2'd0;
            way_reg <= '0;
            found_reg <= 1'b0;
            if (req.address_is_ipv6)
            begin
                hs_reg <= req.source_addr_high[63:32];
                hd_reg <= req.dest_addr_high[63:32];
            end
            else
            begin
                hs_reg <= req.source_addr_low[31:0];
                hd_reg <= req.dest_addr_low[31:0];
            end
        end
        if (cmd.hash_step && r_reg.address_is_ipv6)
        begin
            hs_reg <= (hs_reg << 5) - hs_reg + hs_word;
            hd_reg <= (hd_reg << 5) - hd_reg + hd_word;
            hcnt_reg <= hcnt_reg + 2'd1;
        end
        if (cmd.cmp_way && match)
        begin
            found_reg <= 1'b1;
            fway_reg <= way_reg;
        end
        if (cmd.next_way)
        begin
            way_reg <= way_reg + WW'(1);
        end
    end

    // memory read ports
    always_ff @(posedge clk)
    begin
        if (cmd.rd_way)
        begin
            ent_rd <= ent_mem[slot_rd];
            vrow_reg <= vld_mem[bucket];
            for (int m = 0; m < MC; m++)
            begin
                vals_rd[m] <= val_mem[slot_rd][m];
            end
        end
    end

    // execute: decide, write back, form result
    logic          fnd;
    logic          aged;
    logic          free_any;
    logic [WW-1:0] free_way;
    logic [SW-1:0] slot_new;
    logic          idx_ok;
    logic [2:0]    mi;
    logic          ent_we;
    logic          vals_we;
    logic          vld_set;
    logic          vld_clr;
    logic [SW-1:0] slot_wr;
    ent_t          ent_wr;
    logic [31:0]   vals_wr [MC];
    cmc_pkg::rsp_t rsp_next;

    assign fnd = found_reg || match;
    assign aged = (r_reg.now_seconds - ent_rd.touch) > timeout_reg;
    assign idx_ok = r_reg.metric_index < 3'(MC);
    assign mi = r_reg.metric_index;
    assign slot_new = SW'(32'(bucket) * 32'(WAYS) + 32'(free_way));

    always_comb
    begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!vrow_reg[w])
            begin
                free_any = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    // when execute runs after a hit, ent_rd holds the hit way (walk stops on hit)
    // a hit row is rebuilt from the read copy and written back at most once; a new entry is built from the request
    always_comb
    begin
        rsp_next = '0;
        ent_wr = ent_rd;
        ent_we = 1'b0;
        vals_we = 1'b0;
        vld_set = 1'b0;
        vld_clr = 1'b0;
        slot_wr = slot_hit;
        for (int m = 0; m < MC; m++)
        begin
            vals_wr[m] = vals_rd[m];
        end
        if (r_reg.req_type > cmc_pkg::REQ_LOCK)
        begin
            rsp_next.status = cmc_pkg::ST_BAD_INDEX;
        end
        else if (r_reg.req_type == cmc_pkg::REQ_ADD)
        begin
            if (fnd)
            begin
                rsp_next.status = cmc_pkg::ST_OK;
                rsp_next.lock_mask = ent_rd.locks;
                if (aged)
                begin
                    ent_wr.touch = r_reg.now_seconds;
                    ent_we = 1'b1;
                    vals_we = 1'b1;
                    for (int m = 0; m < MC; m++)
                    begin
                        vals_wr[m] = '0;
                    end
                end
            end
            else if (!free_any)
            begin
                rsp_next.status = cmc_pkg::ST_FULL;
            end
            else
            begin
                rsp_next.status = cmc_pkg::ST_CREATED;
                vld_set = 1'b1;
                slot_wr = slot_new;
                ent_wr = '{v6: r_reg.address_is_ipv6, sh: shi, sl: slo,
                           dh: dhi, dl: dlo,
                           touch: r_reg.now_seconds, locks: 5'd0};
                ent_we = 1'b1;
                vals_we = 1'b1;
                for (int m = 0; m < MC; m++)
                begin
                    vals_wr[m] = '0;
                end
            end
        end
        else if (!fnd)
        begin
            rsp_next.status = cmc_pkg::ST_NOT_FOUND;
        end
        else if (r_reg.req_type == cmc_pkg::REQ_REMOVE)
        begin
            rsp_next.lock_mask = ent_rd.locks;
            vld_clr = 1'b1;
        end
        else
        begin
            if (aged)
            begin
                ent_wr.touch = r_reg.now_seconds;
                ent_we = 1'b1;
                vals_we = 1'b1;
                for (int m = 0; m < MC; m++)
                begin
                    vals_wr[m] = '0;
                end
            end
            rsp_next.lock_mask = ent_rd.locks;
            if (!idx_ok)
            begin
                rsp_next.status = cmc_pkg::ST_BAD_INDEX;
            end
            else if (r_reg.req_type == cmc_pkg::REQ_UPDATE)
            begin
                if (ent_rd.locks[mi])
                begin
                    rsp_next.status = cmc_pkg::ST_LOCKED;
                end
                else
                begin
                    vals_wr[mi] = r_reg.metric_value_in;
                    vals_we = 1'b1;
                    ent_wr.touch = r_reg.now_seconds;
                    ent_we = 1'b1;
                end
            end
            else if (r_reg.req_type == cmc_pkg::REQ_READ)
            begin
                rsp_next.metric_value_out = aged ? 32'd0 : vals_rd[mi];
            end
            else
            begin
                ent_wr.locks = ent_rd.locks | (5'd1 << mi);
                ent_we = 1'b1;
                rsp_next.lock_mask = ent_rd.locks | (5'd1 << mi);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            vld_mem[clr_reg[BW-1:0]] <= '0;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            if (ent_we)
            begin
                ent_mem[slot_wr] <= ent_wr;
            end
            if (vals_we)
            begin
                for (int m = 0; m < MC; m++)
                begin
                    val_mem[slot_wr][m] <= vals_wr[m];
                end
            end
            if (vld_set)
            begin
                vld_mem[bucket][free_way] <= 1'b1;
            end
            if (vld_clr)
            begin
                vld_mem[bucket][fway_reg] <= 1'b0;
            end
        end
    end

endmodule

@@ verif/cmc_tb_if.sv @@
`timescale 1ns / 1ps

// the block's interfaces are used as they stand; this file only holds the
// beat record that the driver queue carries
package cmc_tb_pkg;
    import cmc_pkg::*;

    typedef struct {
        bit    is_cfg;
        logic [31:0] cfg_value;
        req_t  req;
    } beat_t;
endpackage

@@ verif/tb_connection_metrics_cache_core.sv @@
`timescale 1ns / 1ps

module tb_connection_metrics_cache_core;
    import cmc_pkg::*;
    import cmc_tb_pkg::*;

    localparam int NBUCKETS = DefBuckets;
    localparam int NWAYS = DefWays;
    localparam int NSLOTS = NBUCKETS * NWAYS;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cmc_req_if req_ch ();
    cmc_rsp_if rsp_ch ();
    cmc_cfg_if cfg_ch ();

    connection_metrics_cache_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    // predictor state: a shadow copy of the cache
    logic [31:0] shadow_timeout;
    bit          shadow_valid [NSLOTS];
    bit          shadow_v6 [NSLOTS];
    logic [63:0] shadow_src_hi [NSLOTS];
    logic [63:0] shadow_src_lo [NSLOTS];
    logic [63:0] shadow_dst_hi [NSLOTS];
    logic [63:0] shadow_dst_lo [NSLOTS];
    logic [31:0] shadow_touch [NSLOTS];
    logic [4:0]  shadow_locks [NSLOTS];
    logic [31:0] shadow_metrics [NSLOTS][MetricCount];

    beat_t pending_beats[$];
    rsp_t  expected_rsps[$];
    int    fail_count = 0;
    bit    idle_off = 1'b0;
    bit    long_hold = 1'b0;
    bit    stim_done = 1'b0;

    // key pool so that random requests hit live entries often
    req_t  key_pool[$];

    function automatic logic [31:0] addr_bucket(bit v6, logic [63:0] hi, logic [63:0] lo);
        logic [31:0] h;
        if (!v6)
            h = lo[31:0];
        else
        begin
            h = hi[63:32];
            h = h * 32'd31 + hi[31:0];
            h = h * 32'd31 + lo[63:32];
            h = h * 32'd31 + lo[31:0];
        end
        return h & 32'(NBUCKETS - 1);
    endfunction

    function automatic void age_entry(int s, logic [31:0] now);
        if (32'(now - shadow_touch[s]) > shadow_timeout)
        begin
            for (int m = 0; m < MetricCount; m++)
                shadow_metrics[s][m] = '0;
            shadow_touch[s] = now;
        end
    endfunction

    // works out the one result beat that a request causes
    function automatic rsp_t predict_metrics_rsp(req_t r);
        rsp_t        o;
        bit          v6;
        logic [63:0] shi, slo, dhi, dlo;
        int          base, s, idx;
        bit          found, freed;
        v6  = r.address_is_ipv6;
        shi = v6 ? r.source_addr_high : 64'd0;
        slo = v6 ? r.source_addr_low : {32'd0, r.source_addr_low[31:0]};
        dhi = v6 ? r.dest_addr_high : 64'd0;
        dlo = v6 ? r.dest_addr_low : {32'd0, r.dest_addr_low[31:0]};
        idx = r.metric_index;
        o = '{status: ST_OK, metric_value_out: '0, lock_mask: '0};
        base = (addr_bucket(v6, shi, slo) ^ addr_bucket(v6, dhi, dlo)) * NWAYS;
        found = 1'b0;
        s = 0;
        for (int w = 0; w < NWAYS && !found; w++)
            if (shadow_valid[base + w] && shadow_v6[base + w] == v6 &&
                shadow_src_hi[base + w] == shi && shadow_src_lo[base + w] == slo &&
                shadow_dst_hi[base + w] == dhi && shadow_dst_lo[base + w] == dlo)
            begin
                s = base + w;
                found = 1'b1;
            end
        if (r.req_type > REQ_LOCK)
            o.status = ST_BAD_INDEX;
        else if (r.req_type == REQ_ADD)
        begin
            if (found)
            begin
                age_entry(s, r.now_seconds);
                o.lock_mask = shadow_locks[s];
            end
            else
            begin
                freed = 1'b0;
                for (int w = 0; w < NWAYS && !freed; w++)
                    if (!shadow_valid[base + w])
                    begin
                        s = base + w;
                        freed = 1'b1;
                    end
                if (!freed)
                    o.status = ST_FULL;
                else
                begin
                    shadow_valid[s] = 1'b1;
                    shadow_v6[s] = v6;
                    shadow_src_hi[s] = shi;
                    shadow_src_lo[s] = slo;
                    shadow_dst_hi[s] = dhi;
                    shadow_dst_lo[s] = dlo;
                    shadow_touch[s] = r.now_seconds;
                    shadow_locks[s] = '0;
                    for (int m = 0; m < MetricCount; m++)
                        shadow_metrics[s][m] = '0;
                    o.status = ST_CREATED;
                end
            end
        end
        else if (!found)
            o.status = ST_NOT_FOUND;
        else if (r.req_type == REQ_REMOVE)
        begin
            o.lock_mask = shadow_locks[s];
            shadow_valid[s] = 1'b0;
        end
        else
        begin
            age_entry(s, r.now_seconds);
            if (idx >= MetricCount)
                o.status = ST_BAD_INDEX;
            else if (r.req_type == REQ_UPDATE)
            begin
                if (shadow_locks[s][idx])
                    o.status = ST_LOCKED;
                else
                begin
                    shadow_metrics[s][idx] = r.metric_value_in;
                    shadow_touch[s] = r.now_seconds;
                end
            end
            else if (r.req_type == REQ_READ)
                o.metric_value_out = shadow_metrics[s][idx];
            else
                shadow_locks[s][idx] = 1'b1;
            o.lock_mask = shadow_locks[s];
        end
        return o;
    endfunction

    // random request, mostly aimed at keys already in use
    function automatic req_t random_req(logic [31:0] now);
        req_t r;
        int   pick;
        r.req_type = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 19) == 0)
            r.req_type = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (key_pool.size() > 0 && pick < 7)
        begin
            req_t k;
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.address_is_ipv6 = k.address_is_ipv6;
            r.source_addr_high = k.source_addr_high;
            r.source_addr_low = k.source_addr_low;
            r.dest_addr_high = k.dest_addr_high;
            r.dest_addr_low = k.dest_addr_low;
            // ignored upper bits still toggle on ipv4 keys
            if (!k.address_is_ipv6 && $urandom_range(0, 1))
            begin
                r.source_addr_high = {$urandom, $urandom};
                r.source_addr_low[63:32] = $urandom;
            end
        end
        else
        begin
            r.address_is_ipv6 = 1'($urandom);
            r.source_addr_high = {$urandom, $urandom};
            r.source_addr_low = {$urandom, $urandom};
            r.dest_addr_high = {$urandom, $urandom};
            r.dest_addr_low = {$urandom, $urandom};
            // a small address range crowds buckets so table full shows up
            if (pick == 7 && !r.address_is_ipv6)
            begin
                r.source_addr_low[31:0] = $urandom_range(0, 3);
                r.dest_addr_low[31:0] = $urandom_range(0, 3);
            end
            if (key_pool.size() < 60)
                key_pool.push_back(r);
        end
        r.metric_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
        r.metric_value_in = $urandom;
        r.now_seconds = now;
        return r;
    endfunction

    function automatic req_t key_req(logic [2:0] op, bit v6, logic [63:0] a,
                                     logic [63:0] b, logic [2:0] idx,
                                     logic [31:0] val, logic [31:0] now);
        req_t r;
        r.req_type = op;
        r.address_is_ipv6 = v6;
        r.source_addr_high = a;
        r.source_addr_low = a;
        r.dest_addr_high = b;
        r.dest_addr_low = b;
        r.metric_index = idx;
        r.metric_value_in = val;
        r.now_seconds = now;
        return r;
    endfunction

    task automatic push_req(req_t r);
        beat_t b;
        b.is_cfg = 1'b0;
        b.cfg_value = '0;
        b.req = r;
        pending_beats.push_back(b);
    endtask

    task automatic push_cfg(logic [31:0] v);
        beat_t b;
        b.is_cfg = 1'b1;
        b.cfg_value = v;
        b.req = '0;
        pending_beats.push_back(b);
    endtask

    // driver: one beat at a time from the queue, config beats go to cfg
    int drv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.payload <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.payload <= '0;
        end
        else
        begin
            bit req_done, cfg_done;
            req_done = req_ch.valid && req_ch.ready;
            cfg_done = cfg_ch.valid && cfg_ch.ready;
            if (req_done)
                expected_rsps.push_back(predict_metrics_rsp(req_ch.payload));
            if (cfg_done)
                shadow_timeout = cfg_ch.payload;
            if ((req_ch.valid && !req_done) || (cfg_ch.valid && !cfg_done))
                ; // hold the current beat
            else if (drv_gap > 0)
            begin
                drv_gap <= drv_gap - 1;
                req_ch.valid <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end
            else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].is_cfg && expected_rsps.size() > 0))
            begin
                beat_t b;
                b = pending_beats.pop_front();
                req_ch.valid <= !b.is_cfg;
                cfg_ch.valid <= b.is_cfg;
                req_ch.payload <= b.req;
                cfg_ch.payload <= b.cfg_value;
                if (!idle_off && $urandom_range(0, 5) == 0)
                    drv_gap <= $urandom_range(1, 5);
            end
            else
            begin
                req_ch.valid <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result beat with the oldest expectation
    int mon_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result beat with no request pending");
                    fail_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp_ch.payload.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status,
                               rsp_ch.payload.status);
                        fail_count++;
                    end
                    if (rsp_ch.payload.metric_value_out !== e.metric_value_out)
                    begin
                        $error("metric_value_out expected %0h actual %0h",
                               e.metric_value_out, rsp_ch.payload.metric_value_out);
                        fail_count++;
                    end
                    if (rsp_ch.payload.lock_mask !== e.lock_mask)
                    begin
                        $error("lock_mask expected %0h actual %0h", e.lock_mask,
                               rsp_ch.payload.lock_mask);
                        fail_count++;
                    end
                end
            end
            if (long_hold)
                rsp_ch.ready <= 1'b0;
            else if (mon_gap > 0)
            begin
                mon_gap <= mon_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!idle_off && $urandom_range(0, 5) == 0)
                    mon_gap <= $urandom_range(1, 5);
            end
        end
    end

    // wait until the queue and all expectations drain, then settle
    task automatic drain_all();
        while (pending_beats.size() > 0 || expected_rsps.size() > 0 ||
               req_ch.valid || cfg_ch.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [31:0] now;
        logic [31:0] timeouts [5];
        shadow_timeout = DefTimeout;
        for (int i = 0; i < NSLOTS; i++)
            shadow_valid[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ipv4 and ipv6 entries, all operations, corner cases
        now = 32'd100;
        push_req(key_req(REQ_READ, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));       // missing
        push_req(key_req(REQ_ADD, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));        // created
        push_req(key_req(REQ_ADD, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));        // found
        push_req(key_req(REQ_UPDATE, 1'b0, 64'd5, 64'd9, 3'd4, '1, now));
        push_req(key_req(REQ_READ, 1'b0, 64'd5, 64'd9, 3'd4, 0, now));
        push_req(key_req(REQ_LOCK, 1'b0, 64'd5, 64'd9, 3'd4, 0, now));
        push_req(key_req(REQ_UPDATE, 1'b0, 64'd5, 64'd9, 3'd4, 1, now));     // locked
        push_req(key_req(REQ_READ, 1'b0, 64'd5, 64'd9, 3'd7, 0, now));       // bad index
        push_req(key_req(REQ_READ, 1'b0, 64'd5, 64'd9, 3'd4, 0, now + 4000)); // aged
        push_req(key_req(REQ_REMOVE, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));
        push_req(key_req(REQ_REMOVE, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));     // missing
        // same bucket three times: third add finds the table full
        push_req(key_req(REQ_ADD, 1'b0, 64'd1, 64'd0, 3'd0, 0, now));
        push_req(key_req(REQ_ADD, 1'b0, 64'd0, 64'd1, 3'd0, 0, now));
        push_req(key_req(REQ_ADD, 1'b0, 64'd3, 64'd2, 3'd0, 0, now));
        push_req(key_req(REQ_ADD, 1'b1, '1, '1, 3'd0, 0, '1));
        push_req(key_req(REQ_UPDATE, 1'b1, '1, '1, 3'd0, '1, '1));
        push_req(key_req(REQ_READ, 1'b1, '1, '1, 3'd0, 0, 32'd0));          // wrap, no aging
        push_req(key_req(REQ_ADD, 1'b1, 64'd0, 64'd0, 3'd0, 0, now));
        push_req(key_req(REQ_LOCK, 1'b1, 64'd0, 64'd0, 3'd5, 0, now));
        push_req(key_req(3'd7, 1'b1, '1, '1, 3'd7, '1, '1));                 // unknown op
        push_req(key_req(3'd5, 1'b0, 64'd5, 64'd9, 3'd0, 0, now));
        drain_all();

        timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd10, 32'd1000, DefTimeout};
        foreach (timeouts[p])
        begin
            push_cfg(timeouts[p]);
            for (int i = 0; i < 160; i++)
            begin
                now = now + $urandom_range(0, (p == 2) ? 20 : 300);
                if ($urandom_range(0, 30) == 0)
                    now = $urandom;
                push_req(random_req(now));
            end
            if (p == 1)
            begin
                // long receiver hold while the sender keeps offering
                while (pending_beats.size() > 100)
                    @(posedge clk);
                long_hold = 1'b1;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            if (p == 4)
                idle_off = 1'b1;
            drain_all();
        end
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("tb_connection_metrics_cache_core: PASS");
        else
            $display("tb_connection_metrics_cache_core: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_connection_metrics_cache_core: FAIL");
        $finish;
    end

endmodule
